// File: rtl/core/cpls_pkg.sv
// Shared types and constants of the convex polygon line splitter.
// Used by cpls_front, cpls_back and the top level; depends on nothing else.
package cpls_pkg;

    localparam int MAX_EDGES = 16;
    localparam int MAX_RES   = MAX_EDGES + 4;
    localparam int IDX_W     = $clog2(MAX_EDGES);
    localparam int CNT_W     = $clog2(MAX_EDGES + 1);
    localparam int RES_W     = $clog2(MAX_RES + 1);

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SPLIT  = 1'b1;
    localparam logic SIDE_RIGHT = 1'b0;
    localparam logic SIDE_LEFT  = 1'b1;

    typedef logic signed [63:0] word_t;

    typedef struct packed {
        logic  action;
        word_t start_x;
        word_t start_y;
        word_t start_z;
        word_t line_a;
        word_t line_b;
        word_t line_c;
        logic  final_edge;
    } in_item_t;

    typedef struct packed {
        logic  side;
        word_t out_x;
        word_t out_y;
        word_t out_z;
        word_t out_a;
        word_t out_b;
        word_t out_c;
        logic  last;
        logic  empty_res;
    } out_item_t;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
        word_t a;
        word_t b;
        word_t c;
    } edge_t;

endpackage

// File: rtl/core/cpls_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Self-contained; used for the polygon edge store.
module cpls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/cpls_front.sv
// Front end: takes items off the command port and queues them in order.
// Depends on cpls_pkg.
module cpls_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cpls_pkg::in_item_t item,
    input  logic              pop,
    output logic              cmd_valid,
    output logic              cmd_split,
    output cpls_pkg::in_item_t cmd
);
    import cpls_pkg::*;

    in_item_t   q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    logic       take;

    assign busy      = (fill_reg == 2'd2);
    assign push      = start && !busy;
    assign cmd_valid = (fill_reg != 2'd0);
    assign take      = pop && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];
    assign cmd_split = (q_reg[rd_ptr_reg].action == ACT_SPLIT);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(take);
        end
    end

endmodule

// File: rtl/core/cpls_back.sv
// Back end: edge store, vertex classification, cut-point arithmetic and
// result sequencing. Depends on cpls_pkg and cpls_ram.
module cpls_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  logic               cmd_split,
    input  cpls_pkg::in_item_t  cmd,
    output logic               pop,
    output logic               strobe,
    output cpls_pkg::out_item_t result
);
    import cpls_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLS_RD, ST_CLS_MAC, ST_WALK_RD, ST_WALK_DEC,
        ST_CUT, ST_NORM, ST_EMIT, ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {CLS_ON, CLS_RIGHT, CLS_LEFT} cls_t;

    typedef enum logic [2:0] {
        EA_WHOLE, EA_LR, EA_RL, EA_L, EA_L_ON, EA_R, EA_R_ON, EA_NONE
    } emit_act_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               closed_reg;
    word_t              ln_reg [3];
    logic [IDX_W-1:0]   idx_reg;
    logic [2:0]         term_reg;
    logic [1:0]         part_reg;
    word_t              acc_reg;
    word_t              mid_reg [3];
    cls_t               cls_reg [MAX_EDGES];
    cls_t               first_cls_reg;
    logic               any_l_reg;
    logic               any_r_reg;
    emit_act_t          act_reg;
    logic [1:0]         esub_reg;
    out_item_t          pend_reg;
    logic               pend_v_reg;
    logic [RES_W-1:0]   res_cnt_reg;
    out_item_t          out_reg;
    logic               out_v_reg;

    // Edge store
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [CNT_W-1:0]   load_base;
    edge_t              ram_wdata;
    logic [$bits(edge_t)-1:0] ram_q;
    edge_t              e;

    assign load_base = closed_reg ? '0 : cnt_reg;
    assign ram_we    = (state_reg == ST_IDLE) && cmd_valid && !cmd_split
                       && (load_base < CNT_W'(MAX_EDGES));
    assign ram_waddr = load_base[IDX_W-1:0];
    assign ram_wdata = '{x: cmd.start_x, y: cmd.start_y, z: cmd.start_z,
                         a: cmd.line_a, b: cmd.line_b, c: cmd.line_c};
    assign e         = edge_t'(ram_q);

    cpls_ram #(.WIDTH($bits(edge_t)), .DEPTH(MAX_EDGES)) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(idx_reg),
        .rdata(ram_q)
    );

    assign pop = (state_reg == ST_IDLE) && cmd_valid;

    // Shared 32x32 multiplier: each 64-bit wrapping product is built from
    // three partial products, one per cycle.
    word_t       opa;
    word_t       opb;
    logic        op_sub;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] prod;
    word_t       pp;
    word_t       dot_sum;
    logic        cls_left;
    cls_t        cls_new;

    always_comb
    begin
        opa    = ln_reg[0];
        opb    = e.x;
        op_sub = 1'b0;
        if (state_reg == ST_CLS_MAC)
        begin
            unique case (term_reg)
                3'd0:    begin opa = ln_reg[0]; opb = e.x; end
                3'd1:    begin opa = ln_reg[1]; opb = e.y; end
                default: begin opa = ln_reg[2]; opb = e.z; end
            endcase
        end
        else
        begin
            op_sub = term_reg[0];
            unique case (term_reg)
                3'd0:    begin opa = ln_reg[1]; opb = e.c; end
                3'd1:    begin opa = ln_reg[2]; opb = e.b; end
                3'd2:    begin opa = ln_reg[2]; opb = e.a; end
                3'd3:    begin opa = ln_reg[0]; opb = e.c; end
                3'd4:    begin opa = ln_reg[0]; opb = e.b; end
                default: begin opa = ln_reg[1]; opb = e.a; end
            endcase
        end
        mul_x = (part_reg == 2'd1) ? opa[63:32] : opa[31:0];
        mul_y = (part_reg == 2'd2) ? opb[63:32] : opb[31:0];
        prod  = 64'(mul_x) * 64'(mul_y);
        pp    = (part_reg == 2'd0) ? prod : {prod[31:0], 32'h0};
    end

    // The side value is the negated dot product; it is negative exactly when
    // the sum is positive or is the most negative word.
    assign dot_sum  = acc_reg + pp;
    assign cls_left = ((dot_sum != '0) && !dot_sum[63])
                      || (dot_sum == {1'b1, 63'h0});
    assign cls_new  = (dot_sum == '0) ? CLS_ON : (cls_left ? CLS_LEFT : CLS_RIGHT);

    // Walk decision for the current edge
    logic             at_last;
    cls_t             s1;
    cls_t             s2;
    emit_act_t        act_new;

    assign at_last = (CNT_W'(idx_reg) == cnt_reg - CNT_W'(1));
    assign s1      = cls_reg[0];
    assign s2      = at_last ? first_cls_reg : cls_reg[1];

    always_comb
    begin
        if (!(any_l_reg && any_r_reg))
        begin
            act_new = EA_WHOLE;
        end
        else if (s1 == CLS_LEFT && s2 == CLS_RIGHT)
        begin
            act_new = EA_LR;
        end
        else if (s1 == CLS_RIGHT && s2 == CLS_LEFT)
        begin
            act_new = EA_RL;
        end
        else if (s1 == CLS_LEFT || s2 == CLS_LEFT)
        begin
            act_new = (s1 == CLS_ON) ? EA_L_ON : EA_L;
        end
        else if (s1 == CLS_RIGHT || s2 == CLS_RIGHT)
        begin
            act_new = (s1 == CLS_ON) ? EA_R_ON : EA_R;
        end
        else
        begin
            act_new = EA_NONE;
        end
    end

    // Result built in the emit state
    out_item_t res_new;
    logic      emit_end;
    logic      whole_side;
    out_item_t pend_fin;
    out_item_t empty_item;

    assign whole_side = any_l_reg ? SIDE_LEFT : SIDE_RIGHT;

    always_comb
    begin
        pend_fin             = pend_reg;
        pend_fin.last        = 1'b1;
        empty_item           = '0;
        empty_item.last      = 1'b1;
        empty_item.empty_res = 1'b1;
    end

    always_comb
    begin
        res_new = '{side: SIDE_RIGHT, out_x: e.x, out_y: e.y, out_z: e.z,
                    out_a: e.a, out_b: e.b, out_c: e.c,
                    last: 1'b0, empty_res: 1'b0};
        emit_end = 1'b1;
        unique case (act_reg)
            EA_WHOLE: res_new.side = whole_side;
            EA_LR, EA_RL:
            begin
                emit_end = (esub_reg == 2'd2);
                res_new.side = (act_reg == EA_LR) ? SIDE_LEFT : SIDE_RIGHT;
                if (esub_reg != 2'd0)
                begin
                    res_new.out_x = mid_reg[0];
                    res_new.out_y = mid_reg[1];
                    res_new.out_z = mid_reg[2];
                end
                if (esub_reg == 2'd1)
                begin
                    if (act_reg == EA_LR)
                    begin
                        res_new.out_a = -ln_reg[0];
                        res_new.out_b = -ln_reg[1];
                        res_new.out_c = -ln_reg[2];
                    end
                    else
                    begin
                        res_new.out_a = ln_reg[0];
                        res_new.out_b = ln_reg[1];
                        res_new.out_c = ln_reg[2];
                    end
                end
                if (esub_reg == 2'd2)
                begin
                    res_new.side = (act_reg == EA_LR) ? SIDE_RIGHT : SIDE_LEFT;
                end
            end
            EA_L, EA_L_ON:
            begin
                res_new.side = SIDE_LEFT;
                if (act_reg == EA_L_ON)
                begin
                    emit_end = (esub_reg == 2'd1);
                end
                if (esub_reg == 2'd1)
                begin
                    res_new.side  = SIDE_RIGHT;
                    res_new.out_a = ln_reg[0];
                    res_new.out_b = ln_reg[1];
                    res_new.out_c = ln_reg[2];
                end
            end
            EA_R, EA_R_ON:
            begin
                if (act_reg == EA_R_ON)
                begin
                    emit_end = (esub_reg == 2'd1);
                end
                if (esub_reg == 2'd1)
                begin
                    res_new.side  = SIDE_LEFT;
                    res_new.out_a = -ln_reg[0];
                    res_new.out_b = -ln_reg[1];
                    res_new.out_c = -ln_reg[2];
                end
            end
            EA_NONE: emit_end = 1'b1;
            default: emit_end = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            closed_reg  <= 1'b1;
            idx_reg     <= '0;
            term_reg    <= '0;
            part_reg    <= '0;
            esub_reg    <= '0;
            act_reg     <= EA_NONE;
            any_l_reg   <= 1'b0;
            any_r_reg   <= 1'b0;
            pend_v_reg  <= 1'b0;
            res_cnt_reg <= '0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            out_v_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid && !cmd_split)
                    begin
                        cnt_reg <= (load_base < CNT_W'(MAX_EDGES))
                                   ? load_base + CNT_W'(1) : load_base;
                        closed_reg <= cmd.final_edge;
                    end
                    else if (cmd_valid)
                    begin
                        if (cnt_reg == '0)
                        begin
                            out_reg   <= empty_item;
                            out_v_reg <= 1'b1;
                        end
                        else
                        begin
                            ln_reg[0]   <= cmd.line_a;
                            ln_reg[1]   <= cmd.line_b;
                            ln_reg[2]   <= cmd.line_c;
                            idx_reg     <= '0;
                            any_l_reg   <= 1'b0;
                            any_r_reg   <= 1'b0;
                            res_cnt_reg <= '0;
                            pend_v_reg  <= 1'b0;
                            state_reg   <= ST_CLS_RD;
                        end
                    end
                end
                ST_CLS_RD:
                begin
                    acc_reg   <= '0;
                    term_reg  <= '0;
                    part_reg  <= '0;
                    state_reg <= ST_CLS_MAC;
                end
                ST_CLS_MAC:
                begin
                    acc_reg <= dot_sum;
                    if (part_reg == 2'd2)
                    begin
                        part_reg <= '0;
                        term_reg <= term_reg + 3'd1;
                    end
                    else
                    begin
                        part_reg <= part_reg + 2'd1;
                    end
                    if (part_reg == 2'd2 && term_reg == 3'd2)
                    begin
                        cls_reg[idx_reg] <= cls_new;
                        if (idx_reg == '0)
                        begin
                            first_cls_reg <= cls_new;
                        end
                        if (cls_new == CLS_LEFT)
                        begin
                            any_l_reg <= 1'b1;
                        end
                        if (cls_new == CLS_RIGHT)
                        begin
                            any_r_reg <= 1'b1;
                        end
                        if (at_last)
                        begin
                            idx_reg   <= '0;
                            state_reg <= ST_WALK_RD;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            state_reg <= ST_CLS_RD;
                        end
                    end
                end
                ST_WALK_RD:
                begin
                    state_reg <= ST_WALK_DEC;
                end
                ST_WALK_DEC:
                begin
                    act_reg  <= act_new;
                    esub_reg <= '0;
                    term_reg <= '0;
                    part_reg <= '0;
                    mid_reg[0] <= '0;
                    mid_reg[1] <= '0;
                    mid_reg[2] <= '0;
                    if (act_new == EA_LR || act_new == EA_RL)
                    begin
                        state_reg <= ST_CUT;
                    end
                    else
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_CUT:
                begin
                    if (op_sub)
                    begin
                        mid_reg[term_reg[2:1]] <= mid_reg[term_reg[2:1]] - pp;
                    end
                    else
                    begin
                        mid_reg[term_reg[2:1]] <= mid_reg[term_reg[2:1]] + pp;
                    end
                    if (part_reg == 2'd2)
                    begin
                        part_reg <= '0;
                        term_reg <= term_reg + 3'd1;
                        if (term_reg == 3'd5)
                        begin
                            state_reg <= ST_NORM;
                        end
                    end
                    else
                    begin
                        part_reg <= part_reg + 2'd1;
                    end
                end
                ST_NORM:
                begin
                    if (mid_reg[2][63])
                    begin
                        mid_reg[0] <= -mid_reg[0];
                        mid_reg[1] <= -mid_reg[1];
                        mid_reg[2] <= -mid_reg[2];
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    // A result is held back one step so that last can be set
                    // on whichever turns out to be final.
                    if (act_reg != EA_NONE && res_cnt_reg < RES_W'(MAX_RES))
                    begin
                        res_cnt_reg <= res_cnt_reg + RES_W'(1);
                        pend_reg    <= res_new;
                        pend_v_reg  <= 1'b1;
                        if (pend_v_reg)
                        begin
                            out_reg   <= pend_reg;
                            out_v_reg <= 1'b1;
                        end
                    end
                    esub_reg <= esub_reg + 2'd1;
                    if (emit_end)
                    begin
                        for (int k = 0; k < MAX_EDGES - 1; k++)
                        begin
                            cls_reg[k] <= cls_reg[k + 1];
                        end
                        if (at_last)
                        begin
                            state_reg <= ST_FLUSH;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            state_reg <= ST_WALK_RD;
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (pend_v_reg)
                    begin
                        out_reg   <= pend_fin;
                        out_v_reg <= 1'b1;
                    end
                    pend_v_reg <= 1'b0;
                    state_reg  <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign strobe = out_v_reg;
    assign result = out_reg;

endmodule

// File: rtl/core/convex_polygon_line_splitter_core.sv
// Top level of the convex polygon line splitter.
// Depends on cpls_pkg, cpls_front, cpls_back and cpls_ram.
//
// Usage: an item is transferred on a rising edge where start is high and
// busy is low. A load item (action 0) stores one polygon edge; final_edge
// closes the polygon so that the next load begins a new one. A split item
// (action 1) cuts the stored polygon by the line in line_a/b/c.
// Each result is presented on result for one cycle with strobe high; the
// receiver cannot stall, and the last result of a split has last set.
// A two-entry queue separates the command port from the execution engine,
// so busy rises only when both entries are taken.
// Loads execute at one per cycle while no split is in progress. A split
// first classifies each stored vertex (one 32x32 multiplier, three
// partial products per 64-bit product), then walks the edges, emitting
// the results of each edge and computing the cut point of each crossing
// edge, and a closing step sends the final result.
// An empty store gives a single result flagged empty_res.
// Reset empties the queue and the store; no clearing pass is needed.
module convex_polygon_line_splitter_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  cpls_pkg::in_item_t   item,
    output logic                strobe,
    output cpls_pkg::out_item_t  result
);
    import cpls_pkg::*;

    logic     pop;
    logic     cmd_valid;
    logic     cmd_split;
    in_item_t cmd;

    cpls_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .pop      (pop),
        .cmd_valid(cmd_valid),
        .cmd_split(cmd_split),
        .cmd      (cmd)
    );

    cpls_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_split(cmd_split),
        .cmd      (cmd),
        .pop      (pop),
        .strobe   (strobe),
        .result   (result)
    );

endmodule
